// ----- rtl/msgs_pkg.sv -----
`timescale 1ns / 1ps

package msgs_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 48;
    localparam int INDEX_W = 20;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 10;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BASE = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

endpackage

// ----- rtl/msgs_in_if.sv -----
`timescale 1ns / 1ps

interface msgs_in_if;
    logic                          valid;
    logic                          ready;
    logic [msgs_pkg::INDEX_W-1:0]  word_index;
    logic [msgs_pkg::DATA_W-1:0]   live_word;
    logic [msgs_pkg::DATA_W-1:0]   mark_word;
    logic                          last_word;

    modport source (output valid, word_index, live_word, mark_word, last_word, input ready);
    modport sink   (input valid, word_index, live_word, mark_word, last_word, output ready);
endinterface

// ----- rtl/msgs_out_if.sv -----
`timescale 1ns / 1ps

interface msgs_out_if;
    logic                          valid;
    logic                          ready;
    logic [msgs_pkg::ADDR_W-1:0]   object_address;
    logic                          has_object;
    logic                          batch_end;
    logic [msgs_pkg::COUNT_W-1:0]  batch_count;
    logic                          last_result;

    modport source (output valid, object_address, has_object, batch_end, batch_count,
                    last_result, input ready);
    modport sink   (input valid, object_address, has_object, batch_end, batch_count,
                    last_result, output ready);
endinterface

// ----- rtl/mark_sweep_garbage_scanner_top.sv -----
`timescale 1ns / 1ps
// Sequence: an item is accepted in ST_IDLE, ST_BASE forms the word's base address, then
//   ST_SCAN walks one bit per cycle, holding while the output register is full, up to
//   the highest garbage bit. A new word is accepted only once the scanner is back in
//   ST_IDLE. One bit-step adder/shifter.
// Reset: rst_n clears the sequencer, the batch fill, heap_base and the output valid.
module mark_sweep_garbage_scanner_top #(
    parameter int WORD_BITS   = 64,
    parameter int ALIGNMENT   = 8,
    parameter int BATCH_SLOTS = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [msgs_pkg::ADDR_W-1:0] cfg_wr_data,
    msgs_in_if.sink                     in_ch,
    msgs_out_if.source                  out_ch
);

    localparam int ADDR_W   = msgs_pkg::ADDR_W;
    localparam int INDEX_W  = msgs_pkg::INDEX_W;
    localparam int COUNT_W  = msgs_pkg::COUNT_W;
    // Byte distance between two consecutive bitmap words
    localparam int STRIDE   = WORD_BITS * ALIGNMENT;
    localparam int STRIDE_W = $clog2(STRIDE + 1);
    localparam int PROD_W   = INDEX_W + STRIDE_W;
    // Fill counter holds up to BATCH_SLOTS
    localparam int FILL_W   = $clog2(BATCH_SLOTS + 1);
    // Batch closes once the fill reaches this after a word
    localparam int CLOSE_AT = BATCH_SLOTS - WORD_BITS;

    msgs_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]    heap_base_reg, heap_base_next;
    logic [PROD_W-1:0]    offset_reg, offset_next;     // word_index * STRIDE
    logic [ADDR_W-1:0]    addr_reg, addr_next;         // address of bit 0 of sh_reg
    logic [WORD_BITS-1:0] sh_reg, sh_next;             // remaining garbage bits
    logic                 last_reg, last_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic                 out_has_reg, out_has_next;
    logic                 out_end_reg, out_end_next;
    logic [FILL_W-1:0]    out_count_reg, out_count_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_fire;
    logic                 slot_free;
    logic [WORD_BITS-1:0] sh_rest;
    logic                 rest_empty;
    logic [FILL_W-1:0]    fill_inc;
    logic                 close_batch;

    assign in_ch.ready = (state_reg == msgs_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Output register takes a new item when empty or being drained
    assign slot_free   = !out_valid_reg || out_ch.ready;

    assign sh_rest     = sh_reg >> 1;
    assign rest_empty  = (sh_rest == '0);
    assign fill_inc    = fill_reg + FILL_W'(1);
    assign close_batch = (fill_inc >= FILL_W'(CLOSE_AT)) || last_reg;

    always_comb
    begin
        state_next     = state_reg;
        heap_base_next = heap_base_reg;
        offset_next    = offset_reg;
        addr_next      = addr_reg;
        sh_next        = sh_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;

        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_has_next   = out_has_reg;
        out_end_next   = out_end_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (cfg_wr_en)
        begin
            heap_base_next = cfg_wr_data;
        end

        case (state_reg)
            msgs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Only the low WORD_BITS bits count; upper bits are ignored
                    sh_next     = in_ch.live_word[WORD_BITS-1:0]
                                  & ~in_ch.mark_word[WORD_BITS-1:0];
                    last_next   = in_ch.last_word;
                    offset_next = PROD_W'(in_ch.word_index) * PROD_W'(STRIDE);
                    state_next  = msgs_pkg::ST_BASE;
                end
            end

            msgs_pkg::ST_BASE:
            begin
                addr_next  = heap_base_reg + ADDR_W'(offset_reg);
                state_next = msgs_pkg::ST_SCAN;
            end

            msgs_pkg::ST_SCAN:
            begin
                if (sh_reg == '0)
                begin
                    // Word without garbage: flush marker only on last word, open batch
                    if (last_reg && (fill_reg != '0))
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_addr_next  = '0;
                            out_has_next   = 1'b0;
                            out_end_next   = 1'b1;
                            out_count_next = fill_reg;
                            out_last_next  = 1'b1;
                            fill_next      = '0;
                            state_next     = msgs_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = msgs_pkg::ST_IDLE;
                    end
                end
                else if (!sh_reg[0])
                begin
                    sh_next   = sh_rest;
                    addr_next = addr_reg + ADDR_W'(ALIGNMENT);
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = addr_reg;
                    out_has_next   = 1'b1;
                    out_end_next   = rest_empty && close_batch;
                    out_count_next = fill_inc;
                    out_last_next  = rest_empty;
                    sh_next        = sh_rest;
                    addr_next      = addr_reg + ADDR_W'(ALIGNMENT);
                    fill_next      = fill_inc;
                    if (rest_empty)
                    begin
                        if (close_batch)
                        begin
                            fill_next = '0;
                        end
                        state_next = msgs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = msgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msgs_pkg::ST_IDLE;
            heap_base_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_base_reg <= heap_base_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        offset_reg    <= offset_next;
        addr_reg      <= addr_next;
        sh_reg        <= sh_next;
        last_reg      <= last_next;
        out_addr_reg  <= out_addr_next;
        out_has_reg   <= out_has_next;
        out_end_reg   <= out_end_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.object_address = out_addr_reg;
    assign out_ch.has_object     = out_has_reg;
    assign out_ch.batch_end      = out_end_reg;
    assign out_ch.batch_count    = COUNT_W'(out_count_reg);
    assign out_ch.last_result    = out_last_reg;

endmodule

// ----- test/mark_sweep_garbage_scanner_top_tb.sv -----
`timescale 1ns / 1ps

module mark_sweep_garbage_scanner_top_tb;

    // Block configuration, same as the DUT defaults
    localparam int WORD_BITS   = 64;
    localparam int ALIGNMENT   = 8;
    localparam int BATCH_SLOTS = 512;

    // Cycles the scanner may still spend on a word that emits nothing
    localparam int SETTLE_CYCLES = WORD_BITS + 8;
    // Long output hold-off, long enough to back the scanner up into its input
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 212;
    localparam int PHASES        = 4;

    // Garbage density of a generated word
    typedef enum int {
        DENS_NONE,
        DENS_SINGLE,
        DENS_SPARSE,
        DENS_RANDOM,
        DENS_DENSE,
        DENS_FULL
    } density_t;

    // One result item as seen on the output channel
    typedef struct packed {
        logic [msgs_pkg::ADDR_W-1:0]  object_address;
        logic                         has_object;
        logic                         batch_end;
        logic [msgs_pkg::COUNT_W-1:0] batch_count;
        logic                         last_result;
    } sweep_result_t;

    // Scoreboard: keeps its own heap base and batch fill, turns each accepted
    // word into the garbage addresses it must produce, and checks results in order.
    class sweep_scoreboard;
        logic [msgs_pkg::ADDR_W-1:0] heap_base;
        int unsigned                 batch_fill;
        sweep_result_t               garbage_q[$];
        int                          mismatches;

        function new();
            heap_base  = '0;
            batch_fill = 0;
            mismatches = 0;
        endfunction

        function void set_heap_base(logic [msgs_pkg::ADDR_W-1:0] value);
            heap_base = value;
        endfunction

        function int pending();
            return garbage_q.size();
        endfunction

        // Accepted word: queue one result per garbage bit, lowest bit first.
        function void note_word(logic [msgs_pkg::INDEX_W-1:0] idx,
                                logic [msgs_pkg::DATA_W-1:0] live,
                                logic [msgs_pkg::DATA_W-1:0] mark, logic last);
            logic [msgs_pkg::DATA_W-1:0] garbage;
            logic [msgs_pkg::ADDR_W-1:0] word_base;
            sweep_result_t               r;
            int                          produced;
            garbage   = live & ~mark;
            word_base = heap_base + msgs_pkg::ADDR_W'(idx)
                        * msgs_pkg::ADDR_W'(WORD_BITS * ALIGNMENT);
            produced  = 0;
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (garbage[b])
                begin
                    batch_fill++;
                    r.object_address = word_base + msgs_pkg::ADDR_W'(b * ALIGNMENT);
                    r.has_object     = 1'b1;
                    r.batch_end      = 1'b0;
                    r.batch_count    = msgs_pkg::COUNT_W'(batch_fill);
                    r.last_result    = 1'b0;
                    garbage_q.push_back(r);
                    produced++;
                end
            end
            if (produced > 0)
            begin
                r = garbage_q.pop_back();
                r.last_result = 1'b1;
                // batch keeps room for one more full word; the last word always closes it
                if (batch_fill >= BATCH_SLOTS - WORD_BITS || last)
                begin
                    r.batch_end = 1'b1;
                    batch_fill  = 0;
                end
                garbage_q.push_back(r);
            end
            else if (last && batch_fill > 0)
            begin
                // flush marker for a batch left open at the end of the sweep
                r.object_address = '0;
                r.has_object     = 1'b0;
                r.batch_end      = 1'b1;
                r.batch_count    = msgs_pkg::COUNT_W'(batch_fill);
                r.last_result    = 1'b1;
                garbage_q.push_back(r);
                batch_fill = 0;
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(sweep_result_t got);
            sweep_result_t want;
            if (garbage_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", 64'(got.object_address), '0);
            end
            else
            begin
                want = garbage_q.pop_front();
                if (got.object_address !== want.object_address)
                    report_mismatch("object_address", 64'(got.object_address),
                                    64'(want.object_address));
                if (got.has_object !== want.has_object)
                    report_mismatch("has_object", 64'(got.has_object), 64'(want.has_object));
                if (got.batch_end !== want.batch_end)
                    report_mismatch("batch_end", 64'(got.batch_end), 64'(want.batch_end));
                if (got.batch_count !== want.batch_count)
                    report_mismatch("batch_count", 64'(got.batch_count),
                                    64'(want.batch_count));
                if (got.last_result !== want.last_result)
                    report_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [msgs_pkg::ADDR_W-1:0] cfg_wr_data;

    msgs_in_if  word_ch ();
    msgs_out_if sweep_ch ();

    sweep_scoreboard sb;

    // calm: no idling on either side; hold_request: ask the sink for a long hold-off
    bit calm;
    bit hold_request;
    int words_sent;

    mark_sweep_garbage_scanner_top #(
        .WORD_BITS   (WORD_BITS),
        .ALIGNMENT   (ALIGNMENT),
        .BATCH_SLOTS (BATCH_SLOTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (word_ch),
        .out_ch      (sweep_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Offer one word, idling first now and then, and hold it until accepted.
    // Handshakes are sampled at the edge, before the DUT's own updates land.
    task automatic send_word(input logic [msgs_pkg::INDEX_W-1:0] idx,
                             input logic [msgs_pkg::DATA_W-1:0] live,
                             input logic [msgs_pkg::DATA_W-1:0] mark, input logic last);
        while (!calm && $urandom_range(99) < 22)
        begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.word_index <= idx;
        word_ch.live_word  <= live;
        word_ch.mark_word  <= mark;
        word_ch.last_word  <= last;
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
        sb.note_word(idx, live, mark, last);
        words_sent++;
    endtask

    // Drop valid after a burst (called in the step of the last acceptance)
    task automatic end_burst();
        word_ch.valid <= 1'b0;
    endtask

    // Sender pause: every expected item back, then let a garbage-free word finish
    task automatic wait_drained();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only issued while the scanner is idle
    task automatic write_heap_base(input logic [msgs_pkg::ADDR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_heap_base(value);
    endtask

    function automatic logic [msgs_pkg::DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Build a live/mark pair whose garbage (live & ~mark) has the given density;
    // the remaining live bits are marked, other mark bits are random.
    function automatic void make_word(input density_t dens,
                                      output logic [msgs_pkg::DATA_W-1:0] live,
                                      output logic [msgs_pkg::DATA_W-1:0] mark);
        logic [msgs_pkg::DATA_W-1:0] garbage;
        logic [msgs_pkg::DATA_W-1:0] extra_live;
        case (dens)
            DENS_NONE:   garbage = '0;
            DENS_SINGLE: garbage = msgs_pkg::DATA_W'(1)
                                   << $urandom_range(msgs_pkg::DATA_W - 1);
            DENS_SPARSE: garbage = rand_word() & rand_word() & rand_word();
            DENS_RANDOM: garbage = rand_word();
            DENS_DENSE:  garbage = rand_word() | rand_word();
            default:     garbage = '1;
        endcase
        extra_live = rand_word();
        live = garbage | extra_live;
        mark = ~garbage & (extra_live | rand_word());
    endfunction

    function automatic density_t pick_density();
        int r;
        r = $urandom_range(99);
        if (r < 10)      return DENS_NONE;
        else if (r < 25) return DENS_SINGLE;
        else if (r < 55) return DENS_SPARSE;
        else if (r < 80) return DENS_RANDOM;
        else if (r < 92) return DENS_DENSE;
        else             return DENS_FULL;
    endfunction

    // One sweep range: consecutive word indexes, last_word on the final one.
    // Sometimes the range is cut short (no last word) or replaced by noise.
    task automatic run_sweep();
        logic [msgs_pkg::INDEX_W-1:0] start_idx;
        logic [msgs_pkg::DATA_W-1:0]  live;
        logic [msgs_pkg::DATA_W-1:0]  mark;
        int                           n_words;
        bit                           truncated;
        if ($urandom_range(99) < 15)
        begin
            // noise word: unrelated index, raw bitmaps, random last flag
            send_word(msgs_pkg::INDEX_W'($urandom()), rand_word(), rand_word(),
                      $urandom_range(3) == 0);
        end
        else
        begin
            start_idx = msgs_pkg::INDEX_W'($urandom());
            n_words   = $urandom_range(1, 10);
            truncated = $urandom_range(9) == 0;
            for (int i = 0; i < n_words; i++)
            begin
                make_word(pick_density(), live, mark);
                send_word(start_idx + msgs_pkg::INDEX_W'(i), live, mark,
                          (i == n_words - 1) && !truncated);
            end
        end
    endtask

    // Result sink: checks each accepted item, stalls at random, and honors a
    // requested hold-off by counting it down here.
    initial
    begin : result_sink
        int            hold_left;
        sweep_result_t got;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sweep_ch.valid && sweep_ch.ready)
            begin
                got.object_address = sweep_ch.object_address;
                got.has_object     = sweep_ch.has_object;
                got.batch_end      = sweep_ch.batch_end;
                got.batch_count    = sweep_ch.batch_count;
                got.last_result    = sweep_ch.last_result;
                sb.check_result(got);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sweep_ch.ready <= 1'b0;
            end
            else
            begin
                sweep_ch.ready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [msgs_pkg::ADDR_W-1:0] base;
        int                          target;
        sb           = new();
        calm         = 1'b0;
        hold_request = 1'b0;
        words_sent   = 0;

        // every DUT input known from time zero
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        word_ch.valid      = 1'b0;
        word_ch.word_index = '0;
        word_ch.live_word  = '0;
        word_ch.mark_word  = '0;
        word_ch.last_word  = 1'b0;
        sweep_ch.ready     = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, heap base at its low end ----
        write_heap_base('0);
        // word without garbage, mid-sweep: nothing comes out
        send_word('0, '0, '0, 1'b0);
        // last word, empty batch, no garbage: nothing comes out
        send_word(20'd5, '0, '1, 1'b1);
        // whole word of garbage at index zero: 64 items
        send_word('0, '1, '0, 1'b0);
        // top index, everything still marked
        send_word('1, '1, '1, 1'b0);
        // top bit only, then bottom bit only
        send_word(20'd1, 64'h8000_0000_0000_0000, '0, 1'b0);
        send_word(20'd2, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        // last word with no garbage on an open batch: flush marker
        send_word(20'd3, '0, '0, 1'b1);
        // seven full words reach the batch limit on the seventh
        for (int i = 0; i < 7; i++)
            send_word(msgs_pkg::INDEX_W'(i), '1, '0, 1'b0);
        // last word with garbage closes the batch on its last item
        send_word(20'd7, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        // a new sweep right after the last word starts from an empty batch
        send_word(20'd8, 64'h5555_5555_5555_5555, '0, 1'b1);
        end_burst();
        wait_drained();

        // ---- heap base at its top end: addresses wrap ----
        write_heap_base('1);
        send_word('1, '1, '0, 1'b0);
        send_word(20'h80000, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0FF0_0FF0_0FF0_0FF0, 1'b1);
        end_burst();
        wait_drained();

        // ---- random sweeps in phases with different heap bases ----
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: base = msgs_pkg::ADDR_W'({$urandom(), $urandom()});
                1: base = {24'hFFFFFF, 24'($urandom())};
                2: base = msgs_pkg::ADDR_W'({$urandom(), $urandom()});
                default: base = '0;
            endcase
            write_heap_base(base);
            // first phase runs with no idling at all; the second starts with the
            // sink held off so the scanner backs up into its input
            calm = (phase == 0);
            if (phase == 1)
                hold_request = 1'b1;
            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target)
                run_sweep();
            end_burst();
            wait_drained();
        end

        if (sb.pending() != 0)
            sb.report_mismatch("results never delivered", 64'(sb.pending()), '0);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
